// ===== src/dssp_pkg.sv =====
// Shared types and constants for the decimal size-suffix parser.
package dssp_pkg;

    // Depth of the item queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Character codes used by the classifier and the suffix check.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_UI    = 8'h49;
    localparam logic [7:0] CH_LI    = 8'h69;
    localparam logic [7:0] CH_UK    = 8'h4B;
    localparam logic [7:0] CH_LK    = 8'h6B;
    localparam logic [7:0] CH_UM    = 8'h4D;
    localparam logic [7:0] CH_LM    = 8'h6D;
    localparam logic [7:0] CH_UG    = 8'h47;
    localparam logic [7:0] CH_LG    = 8'h67;

    // Byte classes produced by the front.
    typedef enum logic [2:0] {
        CLS_END,
        CLS_SPACE,
        CLS_SIGN,
        CLS_DIGIT,
        CLS_OTHER
    } cls_t;

    // One classified byte as it travels through the queue.
    typedef struct packed {
        cls_t       cls;
        logic [7:0] ch;
    } item_t;

endpackage

// ===== src/dssp_front.sv =====
// Front of the parser: classifies incoming bytes and queues them for the back.
module dssp_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_ch,
    output logic             item_valid,
    output dssp_pkg::item_t  item,
    input  logic             item_pop
);

    dssp_pkg::item_t                queue_mem [dssp_pkg::QUEUE_DEPTH];
    logic [dssp_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [dssp_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [dssp_pkg::QUEUE_AW:0]    count_reg;
    dssp_pkg::item_t                new_item;
    logic                           push;
    logic                           pop;

    // Byte classification.
    always_comb
    begin
        new_item.ch = in_ch;
        if (in_ch == dssp_pkg::CH_NUL)
            new_item.cls = dssp_pkg::CLS_END;
        else if (in_ch == dssp_pkg::CH_SPACE ||
                 (in_ch >= dssp_pkg::CH_TAB && in_ch <= dssp_pkg::CH_CR))
            new_item.cls = dssp_pkg::CLS_SPACE;
        else if (in_ch == dssp_pkg::CH_PLUS || in_ch == dssp_pkg::CH_MINUS)
            new_item.cls = dssp_pkg::CLS_SIGN;
        else if (in_ch >= dssp_pkg::CH_ZERO && in_ch <= dssp_pkg::CH_NINE)
            new_item.cls = dssp_pkg::CLS_DIGIT;
        else
            new_item.cls = dssp_pkg::CLS_OTHER;
    end

    // Queue handshake.
    assign in_ready   = (count_reg != dssp_pkg::QUEUE_DEPTH[dssp_pkg::QUEUE_AW:0]);
    assign item_valid = (count_reg != '0);
    assign push       = in_valid && in_ready;
    assign pop        = item_pop && item_valid;
    assign item       = queue_mem[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= new_item;
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== src/dssp_back.sv =====
// Back of the parser: runs the parse state, scales the value and holds the result.
module dssp_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             allow_suffix,
    input  logic             item_valid,
    input  dssp_pkg::item_t  item,
    output logic             item_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_ok,
    output logic [63:0]      out_value
);

    typedef enum logic [2:0] {
        PH_WS,
        PH_SIGN,
        PH_DIGITS,
        PH_SUFFIX,
        PH_FAIL
    } phase_t;

    typedef enum logic {
        ENG_RUN,
        ENG_SCALE
    } eng_t;

    phase_t       phase_reg, phase_next;
    eng_t         eng_reg, eng_next;
    logic         negative_reg, negative_next;
    logic [63:0]  mag_reg, mag_next;
    logic         range_err_reg, range_err_next;
    logic [7:0]   sfx_reg [3];
    logic [2:0]   sfx_cnt_reg, sfx_cnt_next;
    logic [63:0]  val_reg, val_next;
    logic [1:0]   scal_reg, scal_next;
    logic         kibi_reg, kibi_next;
    logic         res_ok_reg, res_ok_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_ok_reg, out_ok_next;
    logic [63:0]  out_value_reg, out_value_next;
    logic         sfx_wr;

    logic [67:0]  acc_wide;
    logic [67:0]  limit_wide;
    logic         sfx_ok;
    logic [1:0]   sfx_scal;
    logic         sfx_kibi;
    logic         num_ok;
    logic [63:0]  signed_mag;
    logic [63:0]  val_scaled;

    function automatic logic is_unit(input logic [7:0] c);
        return c == dssp_pkg::CH_UB || c == dssp_pkg::CH_LB;
    endfunction

    function automatic logic is_base(input logic [7:0] c);
        return c == dssp_pkg::CH_UI || c == dssp_pkg::CH_LI;
    endfunction

    // Number of scalings for an exponent letter; zero when not one.
    function automatic logic [1:0] exp_scal(input logic [7:0] c);
        if (c == dssp_pkg::CH_UK || c == dssp_pkg::CH_LK)
            return 2'd1;
        else if (c == dssp_pkg::CH_UM || c == dssp_pkg::CH_LM)
            return 2'd2;
        else if (c == dssp_pkg::CH_UG || c == dssp_pkg::CH_LG)
            return 2'd3;
        else
            return 2'd0;
    endfunction

    // Next magnitude after one more digit, widened so the range check cannot wrap.
    assign acc_wide   = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                      + {64'd0, item.ch[3:0]};
    assign limit_wide = negative_reg ? {4'd0, 1'b1, 63'd0} : {4'd0, 1'b0, {63{1'b1}}};

    // Suffix check at the terminator.
    always_comb
    begin
        sfx_ok   = 1'b0;
        sfx_scal = 2'd0;
        sfx_kibi = 1'b0;
        case (sfx_cnt_reg)
            3'd1:
            begin
                sfx_scal = exp_scal(sfx_reg[0]);
                sfx_ok   = (sfx_scal != 2'd0) || is_unit(sfx_reg[0]);
            end
            3'd2:
            begin
                sfx_scal = exp_scal(sfx_reg[0]);
                sfx_kibi = !is_unit(sfx_reg[1]);
                sfx_ok   = (sfx_scal != 2'd0) &&
                           (is_unit(sfx_reg[1]) || is_base(sfx_reg[1]));
            end
            3'd3:
            begin
                sfx_scal = exp_scal(sfx_reg[0]);
                sfx_kibi = 1'b1;
                sfx_ok   = (sfx_scal != 2'd0) && is_base(sfx_reg[1]) &&
                           is_unit(sfx_reg[2]);
            end
            default:
            begin
                sfx_ok = 1'b0;
            end
        endcase
    end

    assign num_ok     = (phase_reg == PH_DIGITS || phase_reg == PH_SUFFIX) && !range_err_reg;
    assign signed_mag = negative_reg ? (64'd0 - mag_reg) : mag_reg;

    // One scaling step: times 1024 by shift, times 1000 as 1024 - 16 - 8.
    assign val_scaled = kibi_reg ? {val_reg[53:0], 10'd0}
                      : ({val_reg[53:0], 10'd0} - {val_reg[59:0], 4'd0}
                         - {val_reg[60:0], 3'd0});

    assign item_pop = item_valid && (eng_reg == ENG_RUN);

    // Parse, scale and result logic.
    always_comb
    begin
        phase_next     = phase_reg;
        eng_next       = eng_reg;
        negative_next  = negative_reg;
        mag_next       = mag_reg;
        range_err_next = range_err_reg;
        sfx_cnt_next   = sfx_cnt_reg;
        sfx_wr         = 1'b0;
        val_next       = val_reg;
        scal_next      = scal_reg;
        kibi_next      = kibi_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_ok_next    = out_ok_reg;
        out_value_next = out_value_reg;

        if (eng_reg == ENG_SCALE)
        begin
            if (scal_reg != 2'd0)
            begin
                val_next  = val_scaled;
                scal_next = scal_reg - 2'd1;
            end
            else if (!out_valid_reg || out_ready)
            begin
                out_valid_next = 1'b1;
                out_ok_next    = res_ok_reg;
                out_value_next = res_ok_reg ? val_reg : 64'd0;
                eng_next       = ENG_RUN;
            end
        end
        else if (item_valid)
        begin
            case (item.cls)
                dssp_pkg::CLS_END:
                begin
                    // Decide validity and start the scaling steps.
                    if (!num_ok)
                        res_ok_next = 1'b0;
                    else if (sfx_cnt_reg == 3'd0)
                        res_ok_next = 1'b1;
                    else
                        res_ok_next = allow_suffix && sfx_ok;
                    val_next       = signed_mag;
                    scal_next      = (num_ok && allow_suffix && sfx_ok) ? sfx_scal : 2'd0;
                    kibi_next      = sfx_kibi;
                    eng_next       = ENG_SCALE;
                    phase_next     = PH_WS;
                    negative_next  = 1'b0;
                    mag_next       = 64'd0;
                    range_err_next = 1'b0;
                    sfx_cnt_next   = 3'd0;
                end
                default:
                begin
                    case (phase_reg)
                        PH_WS:
                        begin
                            if (item.cls == dssp_pkg::CLS_SIGN)
                            begin
                                negative_next = (item.ch == dssp_pkg::CH_MINUS);
                                phase_next    = PH_SIGN;
                            end
                            else if (item.cls == dssp_pkg::CLS_DIGIT)
                                phase_next = PH_DIGITS;
                            else if (item.cls != dssp_pkg::CLS_SPACE)
                                phase_next = PH_FAIL;
                        end
                        PH_SIGN:
                        begin
                            phase_next = (item.cls == dssp_pkg::CLS_DIGIT) ? PH_DIGITS
                                                                           : PH_FAIL;
                        end
                        PH_DIGITS:
                        begin
                            if (item.cls != dssp_pkg::CLS_DIGIT)
                            begin
                                phase_next   = PH_SUFFIX;
                                sfx_wr       = 1'b1;
                                sfx_cnt_next = 3'd1;
                            end
                        end
                        PH_SUFFIX:
                        begin
                            if (sfx_cnt_reg < 3'd3)
                            begin
                                sfx_wr       = 1'b1;
                                sfx_cnt_next = sfx_cnt_reg + 3'd1;
                            end
                            else
                                sfx_cnt_next = 3'd4;
                        end
                        default:
                        begin
                            phase_next = PH_FAIL;
                        end
                    endcase

                    // Digit accumulation with the signed 64-bit range check.
                    if (item.cls == dssp_pkg::CLS_DIGIT && !range_err_reg &&
                        (phase_reg == PH_WS || phase_reg == PH_SIGN ||
                         phase_reg == PH_DIGITS))
                    begin
                        if (acc_wide > limit_wide)
                            range_err_next = 1'b1;
                        else
                            mag_next = acc_wide[63:0];
                    end
                end
            endcase
        end
    end

    // Suffix character store.
    always_ff @(posedge clk)
    begin
        if (sfx_wr)
            sfx_reg[sfx_cnt_reg[1:0]] <= item.ch;
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WS;
            eng_reg       <= ENG_RUN;
            negative_reg  <= 1'b0;
            mag_reg       <= 64'd0;
            range_err_reg <= 1'b0;
            sfx_cnt_reg   <= 3'd0;
            scal_reg      <= 2'd0;
            res_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            val_reg       <= 64'd0;
            kibi_reg      <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_value_reg <= 64'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            eng_reg       <= eng_next;
            negative_reg  <= negative_next;
            mag_reg       <= mag_next;
            range_err_reg <= range_err_next;
            sfx_cnt_reg   <= sfx_cnt_next;
            scal_reg      <= scal_next;
            res_ok_reg    <= res_ok_next;
            out_valid_reg <= out_valid_next;
            val_reg       <= val_next;
            kibi_reg      <= kibi_next;
            out_ok_reg    <= out_ok_next;
            out_value_reg <= out_value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ok    = out_ok_reg;
    assign out_value = out_value_reg;

endmodule

// ===== src/decimal_size_suffix_parser_top.sv =====
// Top level of the decimal size-suffix parser.
//
// Input stream: one string byte per word on s_axis_tdata; a zero byte ends
// the string. Output stream: one word per string, m_axis_tuser is the ok
// flag and m_axis_tdata the signed 64-bit value (zero when ok is low).
// Configuration: cfg_data[0] writes allow_suffix (reset 1); cfg_ready is
// always high. Write it only while the parser is idle.
//
// A front stage classifies each byte and puts it in a four-word queue; the
// back stage takes one queued word per cycle while it is not busy with a
// terminator. For a terminator the back checks the string, runs zero to
// three scaling steps (by the k/m/g exponent, done by a shared
// shift-and-subtract unit) and loads the output register, and it takes no
// new word from the queue until the result is loaded.
//
// Reset clears the queue, the parse state and the output register. While
// the receiver stalls the result is held; the queue keeps taking bytes
// until it is full, then s_axis_tready drops.
module decimal_size_suffix_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] value
    output logic        m_axis_tuser,   // [0] ok
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic             allow_suffix_reg;
    logic             item_valid;
    logic             item_pop;
    dssp_pkg::item_t  item;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            allow_suffix_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            allow_suffix_reg <= cfg_data;
    end

    // Byte classifier and queue.
    dssp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_ch      (s_axis_tdata),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // Parser, scaler and output register.
    dssp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .allow_suffix (allow_suffix_reg),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_ok       (m_axis_tuser),
        .out_value    (m_axis_tdata)
    );

endmodule

// ===== test/tb_decimal_size_suffix_parser_top.sv =====
// Self-checking testbench for the decimal size-suffix parser top level.
`timescale 1ns / 1ps

module tb_decimal_size_suffix_parser_top;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int SEGMENTS      = 10;
    localparam int SEGMENT_BYTES = 105;
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_CASES     = 24;

    // Parse phases of the predictor.
    typedef enum logic [2:0] {
        ST_LEAD,
        ST_SIGNED,
        ST_NUM,
        ST_SUFFIX,
        ST_BAD
    } parse_state_t;

    // One parsed size as the block reports it.
    typedef struct packed {
        logic        ok;
        logic [63:0] value;
    } size_word_t;

    // One directed string; typed rows carry a hand-written result.
    typedef struct {
        string       text;
        bit          mode;
        bit          typed;
        bit          ok;
        logic [63:0] value;
    } size_case_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] ch
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [63:0] value
    logic        m_axis_tuser;   // [0] ok
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    // Predictor state and the mode it was last given.
    parse_state_t parse_state;
    logic         is_negative;
    logic [63:0]  magnitude;
    logic         saw_digit;
    logic         overflowed;
    logic [7:0]   suffix_bytes [3];
    logic [2:0]   suffix_used;
    logic         suffix_mode;

    size_word_t expected_sizes [$];
    logic [7:0] text_bytes [$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_left       = 0;
    int bytes_sent      = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    size_case_t directed_cases [NUM_CASES] = '{
        '{"",                      1'b1, 1'b1, 1'b0, 64'd0},
        '{" \011 ",                1'b1, 1'b1, 1'b0, 64'd0},
        '{"-",                     1'b1, 1'b1, 1'b0, 64'd0},
        '{"+ 7",                   1'b1, 1'b1, 1'b0, 64'd0},
        '{"q12",                   1'b1, 1'b1, 1'b0, 64'd0},
        '{"\377",                  1'b1, 1'b1, 1'b0, 64'd0},
        '{"9223372036854775807",   1'b1, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF},
        '{"-9223372036854775808",  1'b1, 1'b1, 1'b1, 64'h8000_0000_0000_0000},
        '{"9223372036854775808",   1'b1, 1'b1, 1'b0, 64'd0},
        '{"\011\012\013\014\015 42", 1'b1, 1'b1, 1'b1, 64'd42},
        '{"+0",                    1'b1, 1'b1, 1'b1, 64'd0},
        '{"1k",                    1'b1, 1'b1, 1'b1, 64'd1000},
        '{"1KiB",                  1'b1, 1'b1, 1'b1, 64'd1024},
        '{"5b",                    1'b1, 1'b1, 1'b1, 64'd5},
        '{"3gB",                   1'b1, 1'b0, 1'b0, 64'd0},
        '{"-2Mi",                  1'b1, 1'b0, 1'b0, 64'd0},
        '{"9223372036854775807Gi", 1'b1, 1'b0, 1'b0, 64'd0},
        '{"7x",                    1'b1, 1'b1, 1'b0, 64'd0},
        '{"1kx",                   1'b1, 1'b1, 1'b0, 64'd0},
        '{"1kiX",                  1'b1, 1'b1, 1'b0, 64'd0},
        '{"1kiBB",                 1'b1, 1'b1, 1'b0, 64'd0},
        '{"1Bk",                   1'b1, 1'b1, 1'b0, 64'd0},
        '{"12k",                   1'b0, 1'b1, 1'b0, 64'd0},
        '{"-12",                   1'b0, 1'b0, 1'b0, 64'd0}
    };

    decimal_size_suffix_parser_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Return the predictor to the start of a string.
    function automatic void clear_parse();
        parse_state     = ST_LEAD;
        is_negative     = 1'b0;
        magnitude       = 64'd0;
        saw_digit       = 1'b0;
        overflowed      = 1'b0;
        suffix_bytes[0] = 8'd0;
        suffix_bytes[1] = 8'd0;
        suffix_bytes[2] = 8'd0;
        suffix_used     = 3'd0;
    endfunction

    function automatic logic is_unit_byte(logic [7:0] c);
        return c == dssp_pkg::CH_UB || c == dssp_pkg::CH_LB;
    endfunction

    function automatic logic is_digit_byte(logic [7:0] c);
        return c >= dssp_pkg::CH_ZERO && c <= dssp_pkg::CH_NINE;
    endfunction

    // Accumulate one digit; the bound depends on the sign seen so far.
    function automatic void add_digit(logic [7:0] c);
        logic [63:0] d;
        logic [63:0] bound;
        d = 64'(c - dssp_pkg::CH_ZERO);
        bound = is_negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        saw_digit = 1'b1;
        if (!overflowed)
        begin
            if (magnitude > (bound - d) / 64'd10)
                overflowed = 1'b1;
            else
                magnitude = magnitude * 64'd10 + d;
        end
    endfunction

    // Scale v by the stored suffix; returns 0 when the suffix is malformed.
    function automatic logic scale_by_suffix(inout logic [63:0] v);
        logic [7:0]  e;
        logic [7:0]  base;
        logic [7:0]  unit;
        logic [63:0] factor;
        int          steps;
        e = 8'd0;
        base = 8'd0;
        unit = 8'd0;
        if (suffix_used > 3'd3)
            return 1'b0;
        if (suffix_used == 3'd1)
        begin
            if (suffix_bytes[0] inside {dssp_pkg::CH_LK, dssp_pkg::CH_UK,
                                        dssp_pkg::CH_LM, dssp_pkg::CH_UM,
                                        dssp_pkg::CH_LG, dssp_pkg::CH_UG})
                e = suffix_bytes[0];
            else if (is_unit_byte(suffix_bytes[0]))
                unit = suffix_bytes[0];
            else
                return 1'b0;
        end
        else if (suffix_used == 3'd2)
        begin
            e = suffix_bytes[0];
            if (is_unit_byte(suffix_bytes[1]))
                unit = suffix_bytes[1];
            else
                base = suffix_bytes[1];
        end
        else if (suffix_used == 3'd3)
        begin
            e = suffix_bytes[0];
            base = suffix_bytes[1];
            unit = suffix_bytes[2];
        end

        if (base == 8'd0)
            factor = 64'd1000;
        else if (base == dssp_pkg::CH_LI || base == dssp_pkg::CH_UI)
            factor = 64'd1024;
        else
            return 1'b0;

        if (unit != 8'd0 && !is_unit_byte(unit))
            return 1'b0;

        if (e == 8'd0)
            steps = 0;
        else if (e == dssp_pkg::CH_LK || e == dssp_pkg::CH_UK)
            steps = 1;
        else if (e == dssp_pkg::CH_LM || e == dssp_pkg::CH_UM)
            steps = 2;
        else if (e == dssp_pkg::CH_LG || e == dssp_pkg::CH_UG)
            steps = 3;
        else
            return 1'b0;

        // Products wrap at 64 bits.
        repeat (steps) v = v * factor;
        return 1'b1;
    endfunction

    // Advance the predictor by one accepted byte; a terminator queues a result.
    function automatic void parse_byte(logic [7:0] c);
        size_word_t w;
        logic [63:0] v;
        if (c == dssp_pkg::CH_NUL)
        begin
            w.ok = 1'b0;
            v = 64'd0;
            if (parse_state != ST_BAD && saw_digit && !overflowed)
            begin
                v = is_negative ? 64'd0 - magnitude : magnitude;
                if (suffix_used == 3'd0)
                    w.ok = 1'b1;
                else if (suffix_mode)
                    w.ok = scale_by_suffix(v);
            end
            w.value = w.ok ? v : 64'd0;
            expected_sizes.push_back(w);
            clear_parse();
            return;
        end

        case (parse_state)
            ST_LEAD:
            begin
                if (c == dssp_pkg::CH_SPACE ||
                    (c >= dssp_pkg::CH_TAB && c <= dssp_pkg::CH_CR))
                begin
                end
                else if (c == dssp_pkg::CH_PLUS || c == dssp_pkg::CH_MINUS)
                begin
                    is_negative = (c == dssp_pkg::CH_MINUS);
                    parse_state = ST_SIGNED;
                end
                else if (is_digit_byte(c))
                begin
                    add_digit(c);
                    parse_state = ST_NUM;
                end
                else
                    parse_state = ST_BAD;
            end
            ST_SIGNED:
            begin
                if (is_digit_byte(c))
                begin
                    add_digit(c);
                    parse_state = ST_NUM;
                end
                else
                    parse_state = ST_BAD;
            end
            ST_NUM:
            begin
                if (is_digit_byte(c))
                    add_digit(c);
                else
                begin
                    parse_state = ST_SUFFIX;
                    suffix_bytes[0] = c;
                    suffix_used = 3'd1;
                end
            end
            ST_SUFFIX:
            begin
                // The count saturates at four, which marks a suffix too long.
                if (suffix_used < 3'd3)
                begin
                    suffix_bytes[suffix_used[1:0]] = c;
                    suffix_used = suffix_used + 3'd1;
                end
                else
                    suffix_used = 3'd4;
            end
            default:
                parse_state = ST_BAD;
        endcase
    endfunction

    // Offer one byte, with random gaps, and wait until it is taken.
    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_byte(c);
        bytes_sent++;
    endtask

    // Change the suffix mode once the parser has drained.
    task automatic set_suffix_mode(input logic m);
        s_axis_tvalid <= 1'b0;
        while (expected_sizes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        suffix_mode = m;
    endtask

    // Build one random string: mostly well-formed sizes, some noise.
    task automatic make_random_string();
        logic [7:0] exps [6] = '{dssp_pkg::CH_LK, dssp_pkg::CH_UK, dssp_pkg::CH_LM,
                                 dssp_pkg::CH_UM, dssp_pkg::CH_LG, dssp_pkg::CH_UG};
        int n;
        int form;
        text_bytes.delete();

        // Pure noise strings.
        if ($urandom_range(0, 99) < 15)
        begin
            n = $urandom_range(0, 6);
            repeat (n) text_bytes.push_back(8'($urandom_range(1, 255)));
            return;
        end

        // Leading whitespace and sign.
        repeat ($urandom_range(0, 2))
        begin
            n = $urandom_range(8, 13);
            text_bytes.push_back(n == 8 ? dssp_pkg::CH_SPACE : 8'(n));
        end
        case ($urandom_range(0, 3))
            0: text_bytes.push_back(dssp_pkg::CH_PLUS);
            1: text_bytes.push_back(dssp_pkg::CH_MINUS);
            default: ;
        endcase

        // Digits; long runs probe the overflow bound.
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(17, 21);
            text_bytes.push_back($urandom_range(0, 1) ? dssp_pkg::CH_NINE
                                 : 8'(dssp_pkg::CH_ZERO + $urandom_range(1, 9)));
            n--;
        end
        else
            n = $urandom_range(1, 7);
        repeat (n) text_bytes.push_back(8'(dssp_pkg::CH_ZERO + $urandom_range(0, 9)));

        // Suffix: none, one of the legal shapes, or junk.
        form = $urandom_range(0, 99);
        if (form >= 20 && form < 85)
        begin
            case ($urandom_range(0, 4))
                0: text_bytes.push_back(exps[$urandom_range(0, 5)]);
                1: text_bytes.push_back($urandom_range(0, 1) ? dssp_pkg::CH_LB
                                                             : dssp_pkg::CH_UB);
                2:
                begin
                    text_bytes.push_back(exps[$urandom_range(0, 5)]);
                    text_bytes.push_back($urandom_range(0, 1) ? dssp_pkg::CH_LI
                                                              : dssp_pkg::CH_UI);
                end
                3:
                begin
                    text_bytes.push_back(exps[$urandom_range(0, 5)]);
                    text_bytes.push_back($urandom_range(0, 1) ? dssp_pkg::CH_LB
                                                              : dssp_pkg::CH_UB);
                end
                default:
                begin
                    text_bytes.push_back(exps[$urandom_range(0, 5)]);
                    text_bytes.push_back($urandom_range(0, 1) ? dssp_pkg::CH_LI
                                                              : dssp_pkg::CH_UI);
                    text_bytes.push_back($urandom_range(0, 1) ? dssp_pkg::CH_LB
                                                              : dssp_pkg::CH_UB);
                end
            endcase
        end
        else if (form >= 85)
        begin
            repeat ($urandom_range(1, 4))
                text_bytes.push_back($urandom_range(0, 1) ? exps[$urandom_range(0, 5)]
                                                          : 8'($urandom_range(1, 255)));
        end

        // Occasionally break the string with one stray byte.
        if ($urandom_range(0, 9) == 0)
            text_bytes.insert($urandom_range(0, text_bytes.size()),
                              8'($urandom_range(1, 255)));
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each result word with the oldest expected size.
    always @(posedge clk)
    begin
        size_word_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_sizes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected word: expected none, got ok=%0b value=%0d",
                         $time, m_axis_tuser, $signed(m_axis_tdata));
            end
            else
            begin
                w = expected_sizes.pop_front();
                if (m_axis_tuser !== w.ok)
                begin
                    mismatch_count++;
                    $display("%0t: ok mismatch: expected %0b, got %0b",
                             $time, w.ok, m_axis_tuser);
                end
                if (m_axis_tdata !== w.value)
                begin
                    mismatch_count++;
                    $display("%0t: value mismatch: expected %0d, got %0d",
                             $time, $signed(w.value), $signed(m_axis_tdata));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_decimal_size_suffix_parser_top: errors");
            $finish;
        end
    end

    // Main sequence: reset, directed strings, then random segments.
    initial
    begin
        size_case_t row;
        int         seg_start;
        logic       seg_mode;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        suffix_mode   = 1'b1;
        clear_parse();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_suffix_mode(1'b1);

        // Directed strings; typed rows take the hand-written result.
        for (int r = 0; r < NUM_CASES; r++)
        begin
            row = directed_cases[r];
            if (row.mode != suffix_mode)
                set_suffix_mode(row.mode);
            for (int i = 0; i < row.text.len(); i++)
                send_byte(row.text[i]);
            send_byte(dssp_pkg::CH_NUL);
            if (row.typed)
                expected_sizes[expected_sizes.size() - 1] = '{row.ok, row.value};
        end

        // Random segments over the idle patterns and both modes.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            seg_mode = (seg % 3 != 2);
            if (seg_mode != suffix_mode)
                set_suffix_mode(seg_mode);
            case (seg % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase
            // Long receiver hold-off while bytes keep coming, to fill the queue.
            if (seg == 4)
                hold_left = HOLD_CYCLES;
            seg_start = bytes_sent;
            while (bytes_sent - seg_start < SEGMENT_BYTES)
            begin
                make_random_string();
                foreach (text_bytes[i])
                    send_byte(text_bytes[i]);
                send_byte(dssp_pkg::CH_NUL);
            end
        end

        // Drain and finish.
        s_axis_tvalid <= 1'b0;
        while (expected_sizes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_decimal_size_suffix_parser_top: clean");
        else
            $display("tb_decimal_size_suffix_parser_top: errors");
        $finish;
    end

endmodule
